[rtl/tdc_pkg.sv]
// ----------------------------------------------------------------------------
// TDS probe converter package
// Shared types, constants and fixed-point helpers of the converter.
// ----------------------------------------------------------------------------
package tdc_pkg;

	localparam logic signed [36:0] QLIM = 37'sd68719476735;
	localparam logic signed [36:0] K3 = 37'sd8743854;
	localparam logic signed [36:0] K2 = 37'sd16767836;
	localparam logic signed [36:0] K1 = 37'sd56189911;

	localparam logic [15:0] EC_GAIN_RST = 16'd4096;
	localparam logic [15:0] PPM_SCALE_RST = 16'd32768;
	localparam logic [23:0] CAL_SLOPE_RST = 24'd65536;
	localparam logic [23:0] CAL_OFFSET_RST = 24'd0;
	localparam logic [11:0] FULL_SCALE_RST = 12'd400;

	typedef enum logic [2:0] {
		REG_EC_GAIN    = 3'd0,
		REG_PPM_SCALE  = 3'd1,
		REG_CAL_SLOPE  = 3'd2,
		REG_CAL_OFFSET = 3'd3,
		REG_FULL_SCALE = 3'd4
	} tdc_reg_t;

	typedef struct packed {
		logic [15:0]        ec_gain;
		logic [15:0]        ppm_scale;
		logic [23:0]        cal_slope;
		logic signed [23:0] cal_offset;
		logic [11:0]        full_scale;
	} tdc_cfg_t;

	typedef struct packed {
		logic               inv;
		logic signed [7:0]  temp_c;
	} tdc_tag_t;

	// Saturate to +-(2^36 - 1) in signed Q20.16.
	function automatic logic signed [36:0] sat_q(input logic signed [63:0] x);
		logic signed [63:0] lim;
		lim = 64'(QLIM);
		if (x > lim) begin
			return QLIM;
		end else if (x < -lim) begin
			return -QLIM;
		end
		return x[36:0];
	endfunction

	// Division by 2^sh, truncated toward zero.
	function automatic logic signed [63:0] tdiv_pow2(input logic signed [63:0] x,
		input int unsigned sh);
		logic signed [63:0] bias;
		bias = (64'sd1 <<< sh) - 64'sd1;
		if (x < 0) begin
			return (x + bias) >>> sh;
		end
		return x >>> sh;
	endfunction

endpackage

[rtl/tdc_if.sv]
// ----------------------------------------------------------------------------
// TDS probe converter channels
// Valid/ready channels for samples in and readings out.
// ----------------------------------------------------------------------------
interface tdc_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] adc_code;
	logic signed [11:0] temp_sixteenths;
	logic               temp_valid;

	modport source (output valid, adc_code, temp_sixteenths, temp_valid, input ready);
	modport sink (input valid, adc_code, temp_sixteenths, temp_valid, output ready);
endinterface

interface tdc_out_if;
	logic               valid;
	logic               ready;
	logic [15:0]        tds_ppm;
	logic signed [7:0]  temp_c;
	logic [7:0]         quality_byte;
	logic               valid_res;

	modport source (output valid, tds_ppm, temp_c, quality_byte, valid_res, input ready);
	modport sink (input valid, tds_ppm, temp_c, quality_byte, valid_res, output ready);
endinterface

[rtl/tdc_divider.sv]
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per stage, NW stages, unsigned operands, tag carried along.
// ----------------------------------------------------------------------------
module tdc_divider #(
	parameter int NW = 32,
	parameter int DW = 16,
	parameter int TW = 10
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	input  logic [TW-1:0] tag,
	output logic          out_valid,
	output logic [NW-1:0] quo,
	output logic [TW-1:0] out_tag
);

	logic          vld_s [NW];
	logic [DW-1:0] rem_s [NW];
	logic [NW-1:0] num_s [NW];
	logic [NW-1:0] quo_s [NW];
	logic [DW-1:0] den_s [NW];
	logic [TW-1:0] tag_s [NW];

	for (genvar i = 0; i < NW; i++) begin : g_stage
		logic          vin;
		logic [DW-1:0] rin;
		logic [DW-1:0] din;
		logic [NW-1:0] nin;
		logic [NW-1:0] qin;
		logic [TW-1:0] tin;
		logic [DW:0]   trial;
		logic          ge;

		if (i == 0) begin : g_first
			assign vin = in_valid;
			assign rin = '0;
			assign nin = num;
			assign qin = '0;
			assign din = den;
			assign tin = tag;
		end else begin : g_next
			assign vin = vld_s[i-1];
			assign rin = rem_s[i-1];
			assign nin = num_s[i-1];
			assign qin = quo_s[i-1];
			assign din = den_s[i-1];
			assign tin = tag_s[i-1];
		end

		// The partial remainder stays below the divisor, so DW+1 bits hold the trial.
		assign trial = {rin, nin[NW-1]};
		assign ge = trial >= {1'b0, din};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (en) begin
				vld_s[i] <= vin;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i] <= ge ? DW'(trial - {1'b0, din}) : trial[DW-1:0];
				num_s[i] <= nin << 1;
				quo_s[i] <= {qin[NW-2:0], ge};
				den_s[i] <= din;
				tag_s[i] <= tin;
			end
		end
	end

	assign out_valid = vld_s[NW-1];
	assign quo = quo_s[NW-1];
	assign out_tag = tag_s[NW-1];

endmodule

[rtl/tdc_poly.sv]
// ----------------------------------------------------------------------------
// Conductivity and calibration pipeline
// Cubic in the compensated voltage, gain, TDS factor, slope and offset,
// then the numerator of the quality byte. At most one multiply per stage.
// ----------------------------------------------------------------------------
module tdc_poly import tdc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  tdc_cfg_t    cfg,
	input  logic        in_valid,
	input  logic [26:0] quo,
	input  logic        neg,
	input  tdc_tag_t    tag_in,
	output logic        out_valid,
	output tdc_tag_t    tag_out,
	output logic [15:0] ppm,
	output logic [19:0] qnum
);

	localparam int NS = 13;

	logic [NS-1:0] vld_s;
	tdc_tag_t      tag_s [NS];

	logic signed [27:0] v_in;
	logic signed [27:0] v_s1, v_s2, v_s3, v_s4;
	logic signed [63:0] m_s1, m_s3, m_s5, m_s7, m_s9, m_s11;
	logic signed [36:0] p_s2, p_s4, e_s6, e_s8, e_s10;
	logic [15:0]        ppm_s12, ppm_s13;
	logic [19:0]        qnum_s13;

	logic signed [63:0] prod1, prod3, prod5, prod7, prod9, prod11;
	logic signed [36:0] gain_q, sum12_q;
	logic signed [63:0] sum12;
	logic signed [63:0] ppm_full;
	logic [11:0]        qmin;

	assign v_in = neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});

	assign prod1 = K3 * v_in;
	assign prod3 = p_s2 * v_s2;
	assign prod5 = p_s4 * v_s4;
	assign prod7 = e_s6 * $signed({1'b0, cfg.ec_gain});
	assign prod9 = e_s8 * $signed({1'b0, cfg.ppm_scale});
	assign prod11 = e_s10 * $signed({1'b0, cfg.cal_slope});

	assign gain_q = sat_q(tdiv_pow2(m_s7, 12));
	assign sum12_q = sat_q(tdiv_pow2(m_s11, 16));
	assign sum12 = 64'(sum12_q) + (64'(cfg.cal_offset) <<< 8);
	// A negative sum clamps to zero; otherwise the integer part is taken.
	assign ppm_full = (sum12 < 0) ? 64'sd0 : (sum12 >>> 16);
	assign qmin = (ppm_s12 < {4'b0, cfg.full_scale}) ? ppm_s12[11:0] : cfg.full_scale;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[NS-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_s[0] <= tag_in;
			for (int i = 1; i < NS; i++) begin
				tag_s[i] <= tag_s[i-1];
			end
			m_s1 <= prod1;
			v_s1 <= v_in;
			p_s2 <= sat_q(64'(sat_q(tdiv_pow2(m_s1, 16))) - 64'(K2));
			v_s2 <= v_s1;
			m_s3 <= prod3;
			v_s3 <= v_s2;
			p_s4 <= sat_q(64'(sat_q(tdiv_pow2(m_s3, 16))) + 64'(K1));
			v_s4 <= v_s3;
			m_s5 <= prod5;
			e_s6 <= sat_q(tdiv_pow2(m_s5, 16));
			m_s7 <= prod7;
			e_s8 <= (gain_q < 0) ? 37'sd0 : gain_q;
			m_s9 <= prod9;
			e_s10 <= sat_q(tdiv_pow2(m_s9, 16));
			m_s11 <= prod11;
			ppm_s12 <= (ppm_full > 64'sd65535) ? 16'hFFFF : ppm_full[15:0];
			ppm_s13 <= ppm_s12;
			// Times 255 as times 256 minus one.
			qnum_s13 <= {qmin, 8'b0} - {8'b0, qmin};
		end
	end

	assign out_valid = vld_s[NS-1];
	assign tag_out = tag_s[NS-1];
	assign ppm = ppm_s13;
	assign qnum = qnum_s13;

endmodule

[rtl/tds_probe_converter_top.sv]
// Path from input transfer to result: 1 prepare stage, 32 voltage divider stages,
// 13 calibration pipeline stages, 20 quality divider stages, 1 output register.
// Throughput: one sample per cycle while the output is not stalled; the bit-per-stage
// dividers and at most one multiply per stage set the depth. A stalled output freezes
// the whole pipeline. Reset clears all valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
// TDS probe converter top level
// Temperature-compensated dissolved-solids conversion with APB configuration.
// ----------------------------------------------------------------------------
module tds_probe_converter_top import tdc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	tdc_in_if.sink      in_ch,
	tdc_out_if.source   out_ch,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	tdc_cfg_t cfg_q;
	logic     en;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ec_gain <= EC_GAIN_RST;
			cfg_q.ppm_scale <= PPM_SCALE_RST;
			cfg_q.cal_slope <= CAL_SLOPE_RST;
			cfg_q.cal_offset <= CAL_OFFSET_RST;
			cfg_q.full_scale <= FULL_SCALE_RST;
		end else if (psel && penable && pwrite) begin
			case (tdc_reg_t'(paddr[4:2]))
				REG_EC_GAIN: cfg_q.ec_gain <= pwdata[15:0];
				REG_PPM_SCALE: cfg_q.ppm_scale <= pwdata[15:0];
				REG_CAL_SLOPE: cfg_q.cal_slope <= pwdata[23:0];
				REG_CAL_OFFSET: cfg_q.cal_offset <= pwdata[23:0];
				REG_FULL_SCALE: cfg_q.full_scale <= pwdata[11:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (tdc_reg_t'(paddr[4:2]))
			REG_EC_GAIN: prdata = {16'b0, cfg_q.ec_gain};
			REG_PPM_SCALE: prdata = {16'b0, cfg_q.ppm_scale};
			REG_CAL_SLOPE: prdata = {8'b0, cfg_q.cal_slope};
			REG_CAL_OFFSET: prdata = {8'b0, cfg_q.cal_offset};
			REG_FULL_SCALE: prdata = {20'b0, cfg_q.full_scale};
			default: prdata = '0;
		endcase
	end

	assign pready = 1'b1;

	// Prepare stage.
	logic               out_valid_q;
	logic signed [16:0] coef;
	logic signed [16:0] den17;
	logic signed [12:0] tbias;
	logic signed [16:0] amag;
	logic               inv_c;

	logic               prep_vld_s1;
	logic [31:0]        num_s1;
	logic [15:0]        den_s1;
	logic               neg_s1;
	tdc_tag_t           tag_s1;

	assign en = !out_valid_q || out_ch.ready;
	assign in_ch.ready = en;

	assign inv_c = !in_ch.temp_valid || (in_ch.temp_sixteenths <= -12'sd400);
	assign coef = 17'(in_ch.temp_sixteenths) + 17'sd400;
	assign den17 = (coef <<< 4) + (coef <<< 2);
	assign tbias = 13'(in_ch.temp_sixteenths) + 13'sd15;
	assign amag = in_ch.adc_code[15] ? -17'(in_ch.adc_code) : 17'(in_ch.adc_code);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prep_vld_s1 <= 1'b0;
		end else if (en) begin
			prep_vld_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s1 <= {amag[15:0], 16'b0};
			// An invalid sample still runs through the divider; its result is replaced by zeros.
			den_s1 <= inv_c ? 16'd1 : den17[15:0];
			neg_s1 <= in_ch.adc_code[15];
			tag_s1.inv <= inv_c;
			// Truncation toward zero of sixteenths to whole degrees.
			tag_s1.temp_c <= in_ch.temp_sixteenths[11] ? 8'(tbias >>> 4)
				: 8'(in_ch.temp_sixteenths >>> 4);
		end
	end

	logic        d1_vld;
	logic [31:0] d1_quo;
	logic [9:0]  d1_tag;

	tdc_divider #(.NW(32), .DW(16), .TW(10)) u_vdiv (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(prep_vld_s1), .num(num_s1), .den(den_s1),
		.tag({neg_s1, tag_s1}),
		.out_valid(d1_vld), .quo(d1_quo), .out_tag(d1_tag)
	);

	logic        pl_vld;
	tdc_tag_t    pl_tag;
	logic [15:0] pl_ppm;
	logic [19:0] pl_qnum;

	tdc_poly u_poly (
		.clk(clk), .arst_n(arst_n), .en(en), .cfg(cfg_q),
		.in_valid(d1_vld), .quo(d1_quo[26:0]), .neg(d1_tag[9]),
		.tag_in(tdc_tag_t'(d1_tag[8:0])),
		.out_valid(pl_vld), .tag_out(pl_tag), .ppm(pl_ppm), .qnum(pl_qnum)
	);

	logic        d2_vld;
	logic [19:0] d2_quo;
	logic [24:0] d2_tag;
	tdc_tag_t    d2_info;

	tdc_divider #(.NW(20), .DW(12), .TW(25)) u_qdiv (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(pl_vld), .num(pl_qnum), .den(cfg_q.full_scale),
		.tag({pl_tag, pl_ppm}),
		.out_valid(d2_vld), .quo(d2_quo), .out_tag(d2_tag)
	);

	assign d2_info = tdc_tag_t'(d2_tag[24:16]);

	logic [15:0]       tds_q;
	logic signed [7:0] tc_q;
	logic [7:0]        qb_q;
	logic              vr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= d2_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tds_q <= d2_info.inv ? 16'd0 : d2_tag[15:0];
			tc_q <= d2_info.inv ? 8'sd0 : d2_info.temp_c;
			qb_q <= (d2_info.inv || cfg_q.full_scale == 12'd0) ? 8'd0 : d2_quo[7:0];
			vr_q <= !d2_info.inv;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.tds_ppm = tds_q;
	assign out_ch.temp_c = tc_q;
	assign out_ch.quality_byte = qb_q;
	assign out_ch.valid_res = vr_q;

endmodule

[rtl/tdc_checker.sv]
// ----------------------------------------------------------------------------
// TDS probe converter checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module tdc_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic [15:0]       tds_ppm,
	input logic signed [7:0] temp_c,
	input logic [7:0]        quality_byte,
	input logic              valid_res
);

	// An invalid reading carries only zero fields.
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !valid_res |-> tds_ppm == 16'd0 && temp_c == 8'sd0
			&& quality_byte == 8'd0)
		else $error("invalid reading with nonzero fields");

	// No dissolved solids gives a zero quality byte.
	a_zero_quality: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && tds_ppm == 16'd0 |-> quality_byte == 8'd0)
		else $error("quality byte nonzero at zero ppm");

	// The input side only stalls behind a result that is not taken.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without output backpressure");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(tds_ppm)
			&& $stable(quality_byte) && $stable(temp_c))
		else $error("stalled result changed");

endmodule

bind tds_probe_converter_top tdc_checker u_tdc_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_ready(in_ch.ready),
	.out_valid(out_ch.valid),
	.out_ready(out_ch.ready),
	.tds_ppm(out_ch.tds_ppm),
	.temp_c(out_ch.temp_c),
	.quality_byte(out_ch.quality_byte),
	.valid_res(out_ch.valid_res)
);
